/* sv/triangle_transform_slope_classify_unit_defines.svh */
// Assertion helpers used by the sequencer (ttsc_ctrl). Each use expands to one labeled
// concurrent assertion clocked on i_clk and disabled while i_rst_n is low.
`ifndef TRIANGLE_TRANSFORM_SLOPE_CLASSIFY_UNIT_DEFINES_SVH
`define TRIANGLE_TRANSFORM_SLOPE_CLASSIFY_UNIT_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define TTSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition holds in the cycle after the trigger.
`define TTSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ttsc_pkg.sv */
package ttsc_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int COEF_BITS_DEF  = 16;

    // digit-serial multiplier: digit width and digits of the squared cosine
    localparam int DIGIT_W   = 8;
    localparam int STEEP_W   = 16;
    localparam int C2_W      = 2 * STEEP_W;
    localparam int C2_DIGITS = C2_W / DIGIT_W;
    localparam int SLOPE_SHIFT = 30;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_X       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEEP_COS   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_FLAGS = 4'd7;

    localparam logic [STEEP_W-1:0] STEEP_RESET = 16'd32768;

    localparam logic [1:0] KIND_TRI     = 2'd0;
    localparam logic [1:0] KIND_BOX_MIN = 2'd1;
    localparam logic [1:0] KIND_BOX_MAX = 2'd2;

    localparam logic [7:0] FLAG_WALKABLE = 8'h01;
    localparam logic [7:0] FLAG_STEEP    = 8'h04;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_XFORM,
        ST_EDGE,
        ST_CROSS,
        ST_SQ_LOAD,
        ST_SQ_STEP,
        ST_SQ_ADD,
        ST_RH_LOAD,
        ST_RH_STEP,
        ST_DECIDE,
        ST_OUT_TRI,
        ST_OUT_MIN,
        ST_OUT_MAX
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_XF_MAC,
        OP_XF_FIN,
        OP_EDGE,
        OP_CROSS,
        OP_SQ_LOAD,
        OP_DIGIT,
        OP_SQ_ADD,
        OP_RH_LOAD,
        OP_DECIDE,
        OP_EMIT_MIN,
        OP_EMIT_MAX
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] v;   // vertex
        logic [1:0] a;   // axis
        logic [1:0] j;   // coefficient
        logic [2:0] k;   // cross product term or square select
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_stat;

endpackage

/* sv/ttsc_dpath.sv */
module ttsc_dpath import ttsc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int COEF_BITS  = COEF_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [3*COEF_BITS-1:0]        i_cfg_data,
    input  logic signed [COORD_BITS-1:0]  i_p [3][3],
    input  logic                          i_final_triangle,
    input  t_cmd                          i_cmd,
    output t_stat                         o_stat,
    output logic [1:0]                    o_kind,
    output logic signed [COORD_BITS-1:0]  o_q [3][3],
    output logic [7:0]                    o_tri_flags,
    output logic                          o_run_end
);

    localparam int CB    = COORD_BITS;
    localparam int KB    = COEF_BITS;
    localparam int F     = KB - 2;
    localparam int ROW_W = 3 * KB;
    localparam int MW    = (CB + 2 > KB) ? CB + 2 : KB;
    localparam int PW    = 2 * MW;
    localparam int WT    = KB + CB + 2;
    localparam int EW    = CB + 1;
    localparam int WN    = 2 * CB + 3;
    localparam int WM    = 2 * CB + 2;
    localparam int WX    = 2 * WM + 2;
    localparam int ND    = (WM + DIGIT_W - 1) / DIGIT_W;
    localparam int YW    = ND * DIGIT_W;
    localparam int WA    = WX + C2_W;

    localparam logic signed [WT-1:0] HALF   = WT'(longint'(1) << (F - 1));
    localparam logic signed [WT-1:0] CMAX_T = WT'((longint'(1) << (CB - 1)) - 1);
    localparam logic signed [WT-1:0] CMIN_T = -CMAX_T - WT'(1);
    localparam logic signed [CB-1:0] CMAX   = CB'((longint'(1) << (CB - 1)) - 1);
    localparam logic signed [CB-1:0] CMIN   = -CMAX - CB'(1);

    // configuration and box
    logic [ROW_W-1:0]       r_row [3];
    logic signed [CB-1:0]   r_off [3];
    logic [STEEP_W-1:0]     r_steep;
    logic [7:0]             r_xflags;
    logic signed [CB-1:0]   r_lo [3];
    logic signed [CB-1:0]   r_hi [3];

    // working registers
    logic signed [CB-1:0]   r_p [3][3];
    logic                   r_last;
    logic signed [WT-1:0]   r_acc_t;
    logic signed [CB-1:0]   r_q [3][3];
    logic signed [EW-1:0]   r_e1 [3];
    logic signed [EW-1:0]   r_e2 [3];
    logic signed [WN-1:0]   r_n [3];
    logic [WX-1:0]          r_x;
    logic [YW-1:0]          r_y;
    logic [WA-1:0]          r_acc;
    logic [WX-1:0]          r_len;
    logic [2*WM-1:0]        r_z2;

    logic [1:0]             r_o_kind;
    logic signed [CB-1:0]   r_o_q [3][3];
    logic [7:0]             r_o_flags;
    logic                   r_o_run_end;

    logic signed [MW-1:0]   m_a;
    logic signed [MW-1:0]   m_b;
    logic signed [PW-1:0]   m_p;
    logic signed [KB-1:0]   coef_sel;
    logic signed [WT-1:0]   t_sum;
    logic signed [WT-1:0]   t_rnd;
    logic signed [WT-1:0]   t_sat;
    logic signed [CB-1:0]   q_new;
    logic signed [WN-1:0]   abs_n [3];
    logic [WM-1:0]          sq_sel;
    logic [WX+DIGIT_W-1:0]  dig_p;
    logic [C2_W-1:0]        c2;
    logic [WA-1:0]          lhs;
    logic                   n_zero;
    logic [7:0]             flags;

    assign coef_sel = $signed(r_row[i_cmd.a][i_cmd.j*KB +: KB]);

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (i_cmd.op)
            OP_XF_MAC: begin
                m_a = MW'(coef_sel);
                m_b = MW'(r_p[i_cmd.v][i_cmd.j]);
            end
            OP_CROSS: begin
                case (i_cmd.k)
                    3'd0:    begin m_a = MW'(r_e1[1]); m_b = MW'(r_e2[2]); end
                    3'd1:    begin m_a = MW'(r_e1[2]); m_b = MW'(r_e2[1]); end
                    3'd2:    begin m_a = MW'(r_e1[2]); m_b = MW'(r_e2[0]); end
                    3'd3:    begin m_a = MW'(r_e1[0]); m_b = MW'(r_e2[2]); end
                    3'd4:    begin m_a = MW'(r_e1[0]); m_b = MW'(r_e2[1]); end
                    default: begin m_a = MW'(r_e1[1]); m_b = MW'(r_e2[0]); end
                endcase
            end
            default: ;
        endcase
    end

    assign m_p = m_a * m_b;

    // round half up, then saturate
    always_comb begin
        t_sum = r_acc_t + HALF;
        t_rnd = t_sum >>> F;
        if (t_rnd > CMAX_T) begin
            t_sat = CMAX_T;
        end else if (t_rnd < CMIN_T) begin
            t_sat = CMIN_T;
        end else begin
            t_sat = t_rnd;
        end
        q_new = $signed(t_sat[CB-1:0]);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            abs_n[i] = (r_n[i] < 0) ? -r_n[i] : r_n[i];
        end
        case (i_cmd.k)
            3'd0:    sq_sel = abs_n[2][WM-1:0];
            3'd1:    sq_sel = abs_n[0][WM-1:0];
            default: sq_sel = abs_n[1][WM-1:0];
        endcase
    end

    assign dig_p  = r_x * r_y[YW-1 -: DIGIT_W];
    assign c2     = r_steep * r_steep;
    assign lhs    = WA'(r_z2) << SLOPE_SHIFT;
    assign n_zero = (r_n[0] == '0) && (r_n[1] == '0) && (r_n[2] == '0);

    always_comb begin
        flags = r_xflags;
        if (!n_zero) begin
            if (r_steep == '0) begin
                if (r_n[2] >= 0) begin
                    flags = flags | FLAG_WALKABLE;
                end
            end else if (r_n[2] > 0) begin
                if (lhs >= r_acc) begin
                    flags = flags | FLAG_WALKABLE;
                end
            end else if (r_n[2] < 0) begin
                flags = flags | FLAG_STEEP;
            end
        end
    end

    // configuration and bounding box
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_row[i] <= ROW_W'(1) << (F + i * KB);
                r_off[i] <= '0;
                r_lo[i]  <= CMAX;
                r_hi[i]  <= CMIN;
            end
            r_steep  <= STEEP_RESET;
            r_xflags <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ROW_X:       r_row[0] <= i_cfg_data;
                    CFG_ROW_Y:       r_row[1] <= i_cfg_data;
                    CFG_ROW_Z:       r_row[2] <= i_cfg_data;
                    CFG_OFFSET_X:    r_off[0] <= $signed(i_cfg_data[CB-1:0]);
                    CFG_OFFSET_Y:    r_off[1] <= $signed(i_cfg_data[CB-1:0]);
                    CFG_OFFSET_Z:    r_off[2] <= $signed(i_cfg_data[CB-1:0]);
                    CFG_STEEP_COS:   r_steep  <= i_cfg_data[STEEP_W-1:0];
                    CFG_EXTRA_FLAGS: r_xflags <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_XF_FIN) begin
                if (q_new < r_lo[i_cmd.a]) begin
                    r_lo[i_cmd.a] <= q_new;
                end
                if (q_new > r_hi[i_cmd.a]) begin
                    r_hi[i_cmd.a] <= q_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_p    <= i_p;
                r_last <= i_final_triangle;
            end
            OP_XF_MAC: begin
                if (i_cmd.j == 2'd0) begin
                    r_acc_t <= (WT'(r_off[i_cmd.a]) <<< F) + $signed(m_p[WT-1:0]);
                end else begin
                    r_acc_t <= r_acc_t + $signed(m_p[WT-1:0]);
                end
            end
            OP_XF_FIN: r_q[i_cmd.v][i_cmd.a] <= q_new;
            OP_EDGE: begin
                for (int i = 0; i < 3; i++) begin
                    r_e1[i] <= EW'(r_q[1][i]) - EW'(r_q[0][i]);
                    r_e2[i] <= EW'(r_q[2][i]) - EW'(r_q[0][i]);
                end
            end
            OP_CROSS: begin
                if (!i_cmd.k[0]) begin
                    r_n[i_cmd.k[2:1]] <= $signed(m_p[WN-1:0]);
                end else begin
                    r_n[i_cmd.k[2:1]] <= r_n[i_cmd.k[2:1]] - $signed(m_p[WN-1:0]);
                end
            end
            OP_SQ_LOAD: begin
                r_x   <= WX'(sq_sel);
                r_y   <= YW'(sq_sel);
                r_acc <= '0;
            end
            OP_DIGIT: begin
                r_acc <= (r_acc << DIGIT_W) + WA'(dig_p);
                r_y   <= r_y << DIGIT_W;
            end
            OP_SQ_ADD: begin
                if (i_cmd.k == 3'd0) begin
                    r_len <= WX'(r_acc[2*WM-1:0]);
                    r_z2  <= r_acc[2*WM-1:0];
                end else begin
                    r_len <= r_len + r_acc[WX-1:0];
                end
            end
            OP_RH_LOAD: begin
                r_x   <= r_len;
                r_y   <= YW'(c2) << (YW - C2_W);
                r_acc <= '0;
            end
            OP_DECIDE: begin
                r_o_kind    <= KIND_TRI;
                r_o_q       <= r_q;
                r_o_flags   <= flags;
                r_o_run_end <= !r_last;
            end
            OP_EMIT_MIN, OP_EMIT_MAX: begin
                r_o_kind <= (i_cmd.op == OP_EMIT_MIN) ? KIND_BOX_MIN : KIND_BOX_MAX;
                for (int i = 0; i < 3; i++) begin
                    r_o_q[0][i] <= (i_cmd.op == OP_EMIT_MIN) ? r_lo[i] : r_hi[i];
                    r_o_q[1][i] <= '0;
                    r_o_q[2][i] <= '0;
                end
                r_o_flags   <= '0;
                r_o_run_end <= (i_cmd.op == OP_EMIT_MAX);
            end
            default: ;
        endcase
    end

    assign o_stat.last = r_last;
    assign o_kind      = r_o_kind;
    assign o_q         = r_o_q;
    assign o_tri_flags = r_o_flags;
    assign o_run_end   = r_o_run_end;

endmodule

/* sv/ttsc_ctrl.sv */
`include "triangle_transform_slope_classify_unit_defines.svh"

module ttsc_ctrl import ttsc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam int ND  = (2 * COORD_BITS + 2 + DIGIT_W - 1) / DIGIT_W;
    localparam int DCW = $clog2(ND);

    t_state           r_state, n_state;
    logic [1:0]       r_v, n_v;
    logic [1:0]       r_a, n_a;
    logic [1:0]       r_j, n_j;
    logic [2:0]       r_k, n_k;
    logic [DCW-1:0]   r_d, n_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_v     <= '0;
            r_a     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_d     <= '0;
        end else begin
            r_state <= n_state;
            r_v     <= n_v;
            r_a     <= n_a;
            r_j     <= n_j;
            r_k     <= n_k;
            r_d     <= n_d;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_v         = r_v;
        n_a         = r_a;
        n_j         = r_j;
        n_k         = r_k;
        n_d         = r_d;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '{op: OP_NONE, v: r_v, a: r_a, j: r_j, k: r_k};
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_v      = '0;
                    n_a      = '0;
                    n_j      = '0;
                    n_state  = ST_XFORM;
                end
            end
            ST_XFORM: begin
                if (r_j != 2'd3) begin
                    o_cmd.op = OP_XF_MAC;
                    n_j      = r_j + 2'd1;
                end else begin
                    o_cmd.op = OP_XF_FIN;
                    n_j      = '0;
                    if (r_a == 2'd2) begin
                        n_a = '0;
                        if (r_v == 2'd2) begin
                            n_v     = '0;
                            n_state = ST_EDGE;
                        end else begin
                            n_v = r_v + 2'd1;
                        end
                    end else begin
                        n_a = r_a + 2'd1;
                    end
                end
            end
            ST_EDGE: begin
                o_cmd.op = OP_EDGE;
                n_k      = '0;
                n_state  = ST_CROSS;
            end
            ST_CROSS: begin
                o_cmd.op = OP_CROSS;
                if (r_k == 3'd5) begin
                    n_k     = '0;
                    n_state = ST_SQ_LOAD;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            ST_SQ_LOAD: begin
                o_cmd.op = OP_SQ_LOAD;
                n_d      = '0;
                n_state  = ST_SQ_STEP;
            end
            ST_SQ_STEP: begin
                o_cmd.op = OP_DIGIT;
                if (r_d == DCW'(ND - 1)) begin
                    n_state = ST_SQ_ADD;
                end else begin
                    n_d = r_d + DCW'(1);
                end
            end
            ST_SQ_ADD: begin
                o_cmd.op = OP_SQ_ADD;
                if (r_k == 3'd2) begin
                    n_k     = '0;
                    n_state = ST_RH_LOAD;
                end else begin
                    n_k     = r_k + 3'd1;
                    n_state = ST_SQ_LOAD;
                end
            end
            ST_RH_LOAD: begin
                o_cmd.op = OP_RH_LOAD;
                n_d      = '0;
                n_state  = ST_RH_STEP;
            end
            ST_RH_STEP: begin
                o_cmd.op = OP_DIGIT;
                if (r_d == DCW'(C2_DIGITS - 1)) begin
                    n_state = ST_DECIDE;
                end else begin
                    n_d = r_d + DCW'(1);
                end
            end
            ST_DECIDE: begin
                o_cmd.op = OP_DECIDE;
                n_state  = ST_OUT_TRI;
            end
            ST_OUT_TRI: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_stat.last) begin
                        o_cmd.op = OP_EMIT_MIN;
                        n_state  = ST_OUT_MIN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_OUT_MIN: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.op = OP_EMIT_MAX;
                    n_state  = ST_OUT_MAX;
                end
            end
            ST_OUT_MAX: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `TTSC_ASSERT_NOW(a_ready_excl, o_in_ready, !o_out_valid, "input ready while a result is pending")
    `TTSC_ASSERT_NEXT(a_accept_starts, i_in_valid && o_in_ready, r_state == ST_XFORM, "accepted triangle did not start the transform")
    `TTSC_ASSERT_NEXT(a_decide_emits, r_state == ST_DECIDE, o_out_valid, "classified triangle not presented")
    `TTSC_ASSERT_NOW(a_box_only_last, r_state == ST_OUT_MIN || r_state == ST_OUT_MAX, i_stat.last, "box emitted for a triangle that is not final")

endmodule

/* sv/triangle_transform_slope_classify_unit.sv */
// Triangle transform and slope classification.
// Input channel (i_in_valid / o_in_ready): one transaction is one triangle,
// three vertices in signed Q15.8 plus i_final_triangle. Output channel
// (o_out_valid / i_out_ready): one transaction per result. A triangle gives
// kind 0 with the transformed vertices and its flags; a final triangle is
// followed by kind 1 (box minimum in q0) and kind 2 (box maximum in q0).
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready): write the
// registers only while no triangle is in flight.
// One triangle is processed at a time; a new one is accepted in the cycle
// after the last result of the previous one is taken. Processing uses the
// single shared signed multiplier (27 transform products, 6 cross-product
// steps) and the 8-bit digit-serial multiplier that forms the squared normal
// and compares it with the squared cosine limit.
// Reset restores the identity transform, zero offsets, steep_cos of one,
// no extra flags and an empty bounding box. When the receiver stalls, hold
// the result and accept no new triangle until it is taken.
module triangle_transform_slope_classify_unit import ttsc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int COEF_BITS  = COEF_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [3*COEF_BITS-1:0]        i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_BITS-1:0]  i_p0_x,
    input  logic signed [COORD_BITS-1:0]  i_p0_y,
    input  logic signed [COORD_BITS-1:0]  i_p0_z,
    input  logic signed [COORD_BITS-1:0]  i_p1_x,
    input  logic signed [COORD_BITS-1:0]  i_p1_y,
    input  logic signed [COORD_BITS-1:0]  i_p1_z,
    input  logic signed [COORD_BITS-1:0]  i_p2_x,
    input  logic signed [COORD_BITS-1:0]  i_p2_y,
    input  logic signed [COORD_BITS-1:0]  i_p2_z,
    input  logic                          i_final_triangle,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_kind,
    output logic signed [COORD_BITS-1:0]  o_q0_x,
    output logic signed [COORD_BITS-1:0]  o_q0_y,
    output logic signed [COORD_BITS-1:0]  o_q0_z,
    output logic signed [COORD_BITS-1:0]  o_q1_x,
    output logic signed [COORD_BITS-1:0]  o_q1_y,
    output logic signed [COORD_BITS-1:0]  o_q1_z,
    output logic signed [COORD_BITS-1:0]  o_q2_x,
    output logic signed [COORD_BITS-1:0]  o_q2_y,
    output logic signed [COORD_BITS-1:0]  o_q2_z,
    output logic [7:0]                    o_tri_flags,
    output logic                          o_run_end
);

    t_cmd                         w_cmd;
    t_stat                        w_stat;
    logic signed [COORD_BITS-1:0] w_p [3][3];
    logic signed [COORD_BITS-1:0] w_q [3][3];

    // registers are plain flops: always take a configuration write
    assign o_cfg_ready = 1'b1;

    assign w_p[0][0] = i_p0_x;
    assign w_p[0][1] = i_p0_y;
    assign w_p[0][2] = i_p0_z;
    assign w_p[1][0] = i_p1_x;
    assign w_p[1][1] = i_p1_y;
    assign w_p[1][2] = i_p1_z;
    assign w_p[2][0] = i_p2_x;
    assign w_p[2][1] = i_p2_y;
    assign w_p[2][2] = i_p2_z;

    // sequencer: walks transform, cross product, squares and compare
    ttsc_ctrl #(
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // arithmetic, configuration registers, bounding box and output register
    ttsc_dpath #(
        .COORD_BITS (COORD_BITS),
        .COEF_BITS  (COEF_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_p              (w_p),
        .i_final_triangle (i_final_triangle),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_kind           (o_kind),
        .o_q              (w_q),
        .o_tri_flags      (o_tri_flags),
        .o_run_end        (o_run_end)
    );

    assign o_q0_x = w_q[0][0];
    assign o_q0_y = w_q[0][1];
    assign o_q0_z = w_q[0][2];
    assign o_q1_x = w_q[1][0];
    assign o_q1_y = w_q[1][1];
    assign o_q1_z = w_q[1][2];
    assign o_q2_x = w_q[2][0];
    assign o_q2_y = w_q[2][1];
    assign o_q2_z = w_q[2][2];

endmodule
